/* rtl/pesta_pkg.sv */
package pesta_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int NEST_DEPTH_DEF    = 16;
    localparam int ID_BITS_DEF       = 16;

    typedef enum logic [0:0] {
        CMD_RECORD = 1'b0,
        CMD_DUMP   = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [0:0]  cmd;
        logic [15:0] func_id;
        logic [63:0] start_clock;
        logic [63:0] end_clock;
    } in_word_t;

    typedef struct packed {
        logic [15:0] out_func_id;
        logic [63:0] self_clocks;
        logic [31:0] call_count;
        logic        entry_valid;
        logic        table_overflow;
        logic        stack_overflow;
        logic        last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_UPDATE,
        ST_POP,
        ST_PFIND,
        ST_PARENT,
        ST_PUSH,
        ST_SCAN,
        ST_EMIT,
        ST_WAIT,
        ST_CLEAR
    } state_t;

endpackage

/* rtl/profile_event_self_time_aggregator_core.sv */
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/in_ready   | pesta_pkg::in_word_t
// out     | output    | out_valid/out_ready | pesta_pkg::out_word_t
//
// A record is worked through before the next accept: the N used table slots
// are searched one per cycle by a single id comparator (once for the event,
// once for the parent), and D stack entries are popped one per cycle.
// A dump with N entries makes a selection pass over the table per result,
// with one comparator, picking the largest unemitted total.
// Reset clears the fill count, stack depth and flags; stores need no clear.
// Input is not ready while an item is at work; output stalls hold the word.
module profile_event_self_time_aggregator_core #(
    parameter int TABLE_ENTRIES = pesta_pkg::TABLE_ENTRIES_DEF,
    parameter int NEST_DEPTH    = pesta_pkg::NEST_DEPTH_DEF,
    parameter int ID_BITS       = pesta_pkg::ID_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pesta_pkg::in_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pesta_pkg::out_word_t out_word
);
    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int TC = $clog2(TABLE_ENTRIES + 1);
    localparam int NW = $clog2(NEST_DEPTH);
    localparam int NC = $clog2(NEST_DEPTH + 1);

    // Table storage (memories, one port each side, read data registered)
    logic [ID_BITS-1:0] ids_mem    [TABLE_ENTRIES];
    logic [63:0]        totals_mem [TABLE_ENTRIES];
    logic [31:0]        counts_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] done_reg, done_next; // emitted-in-this-dump marks
    logic [ID_BITS-1:0] nid_mem  [NEST_DEPTH];
    logic [63:0]        nend_mem [NEST_DEPTH];

    pesta_pkg::state_t state_reg, state_next;
    logic [TC-1:0] used_reg, used_next;
    logic [NC-1:0] depth_reg, depth_next;
    logic          tovf_reg, tovf_next, sovf_reg, sovf_next;
    logic [TC-1:0] idx_reg, idx_next;
    logic [TW-1:0] slot_reg, slot_next;
    logic          hit_reg, hit_next;
    logic [ID_BITS-1:0] id_reg, id_next, pid_reg, pid_next;
    logic [63:0]   start_reg, start_next, end_reg, end_next, dur_reg, dur_next;
    logic [63:0]   best_reg, best_next;
    logic [TC-1:0] emitted_reg, emitted_next;
    logic          out_valid_reg, out_valid_next;
    pesta_pkg::out_word_t out_reg, out_next;

    // One read port per store, addressed by the sequencer
    logic [TW-1:0] rd_addr;
    logic [ID_BITS-1:0] rd_id;
    logic [63:0]   rd_tot;
    logic [31:0]   rd_cnt;
    logic [NW-1:0] nrd_addr;
    logic [ID_BITS-1:0] nrd_id;
    logic [63:0]   nrd_end;

    logic          t_we;
    logic [TW-1:0] t_wa;
    logic [ID_BITS-1:0] t_wid;
    logic [63:0]   t_wtot;
    logic [31:0]   t_wcnt;
    logic          n_we;
    logic [NW-1:0] n_wa;

    always_ff @(posedge clk)
    begin
        rd_id  <= ids_mem[rd_addr];
        rd_tot <= totals_mem[rd_addr];
        rd_cnt <= counts_mem[rd_addr];
        if (t_we)
        begin
            ids_mem[t_wa]    <= t_wid;
            totals_mem[t_wa] <= t_wtot;
            counts_mem[t_wa] <= t_wcnt;
        end
    end

    always_ff @(posedge clk)
    begin
        nrd_id  <= nid_mem[nrd_addr];
        nrd_end <= nend_mem[nrd_addr];
        if (n_we)
        begin
            nid_mem[n_wa]  <= id_reg;
            nend_mem[n_wa] <= end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pesta_pkg::ST_IDLE;
            used_reg      <= '0;
            depth_reg     <= '0;
            tovf_reg      <= 1'b0;
            sovf_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            depth_reg     <= depth_next;
            tovf_reg      <= tovf_next;
            sovf_reg      <= sovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        slot_reg    <= slot_next;
        hit_reg     <= hit_next;
        id_reg      <= id_next;
        pid_reg     <= pid_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        dur_reg     <= dur_next;
        best_reg    <= best_next;
        emitted_reg <= emitted_next;
        done_reg    <= done_next;
        out_reg     <= out_next;
    end

    assign in_ready  = (state_reg == pesta_pkg::ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // Index of the previous read, used to pair with registered read data
    logic [TW-1:0] prev_idx;
    logic [NW-1:0] top_idx;
    assign prev_idx = TW'(idx_reg - TC'(1));
    assign top_idx  = NW'(depth_reg - NC'(1));

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        depth_next     = depth_reg;
        tovf_next      = tovf_reg;
        sovf_next      = sovf_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        id_next        = id_reg;
        pid_next       = pid_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        dur_next       = dur_reg;
        best_next      = best_reg;
        emitted_next   = emitted_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_addr        = TW'(idx_reg);
        nrd_addr       = top_idx;
        t_we           = 1'b0;
        t_wa           = slot_reg;
        t_wid          = id_reg;
        t_wtot         = rd_tot;
        t_wcnt         = rd_cnt;
        n_we           = 1'b0;
        n_wa           = NW'(depth_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pesta_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    id_next    = ID_BITS'(in_word.func_id);
                    start_next = in_word.start_clock;
                    end_next   = in_word.end_clock;
                    dur_next   = in_word.end_clock - in_word.start_clock;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    if (in_word.cmd == pesta_pkg::CMD_DUMP)
                    begin
                        done_next    = '0;
                        emitted_next = '0;
                        state_next   = pesta_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = pesta_pkg::ST_FIND;
                    end
                end
            end

            // Walk the table one slot a cycle; read data is registered
            pesta_pkg::ST_FIND:
            begin
                if (idx_reg != '0 && !hit_reg && rd_id == id_reg)
                begin
                    hit_next  = 1'b1;
                    slot_next = prev_idx;
                end
                if (idx_reg == used_reg || (idx_reg != '0 && rd_id == id_reg))
                begin
                    if (!(idx_reg != '0 && rd_id == id_reg) && !hit_reg)
                    begin
                        if (used_reg == TC'(TABLE_ENTRIES))
                        begin
                            tovf_next  = 1'b1;
                            state_next = pesta_pkg::ST_IDLE;
                        end
                        else
                        begin
                            // allocate fresh entry: total = dur, count = 1
                            t_we      = 1'b1;
                            t_wa      = TW'(used_reg);
                            t_wtot    = dur_reg;
                            t_wcnt    = 32'd1;
                            used_next = used_reg + TC'(1);
                            state_next = pesta_pkg::ST_POP;
                        end
                    end
                    else
                    begin
                        rd_addr    = (idx_reg != '0 && rd_id == id_reg) ? prev_idx : slot_reg;
                        slot_next  = rd_addr;
                        state_next = pesta_pkg::ST_UPDATE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + TC'(1);
                end
            end

            pesta_pkg::ST_UPDATE:
            begin
                t_we       = 1'b1;
                t_wtot     = rd_tot + dur_reg;
                t_wcnt     = rd_cnt + 32'd1;
                state_next = pesta_pkg::ST_POP;
            end

            // Stack top is read each cycle; pop while it ended before start
            pesta_pkg::ST_POP:
            begin
                state_next = pesta_pkg::ST_PFIND;
                idx_next   = '0;
                hit_next   = 1'b0;
                if (depth_reg == '0)
                begin
                    state_next = pesta_pkg::ST_PUSH;
                end
                else
                begin
                    state_next = pesta_pkg::ST_PARENT;
                end
            end

            pesta_pkg::ST_PARENT:
            begin
                // nrd_* holds top entry read in the previous cycle
                if (start_reg > nrd_end)
                begin
                    depth_next = depth_reg - NC'(1);
                    nrd_addr   = NW'(depth_reg - NC'(2));
                    if (depth_reg == NC'(1))
                    begin
                        state_next = pesta_pkg::ST_PUSH;
                    end
                end
                else
                begin
                    pid_next   = nrd_id;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = pesta_pkg::ST_PFIND;
                end
            end

            pesta_pkg::ST_PFIND:
            begin
                if (idx_reg != '0 && rd_id == pid_reg)
                begin
                    rd_addr    = prev_idx;
                    slot_next  = prev_idx;
                    hit_next   = 1'b1;
                    state_next = pesta_pkg::ST_WAIT;
                end
                else if (idx_reg == used_reg)
                begin
                    state_next = pesta_pkg::ST_PUSH;
                end
                else
                begin
                    idx_next = idx_reg + TC'(1);
                end
            end

            pesta_pkg::ST_WAIT:
            begin
                t_we       = 1'b1;
                t_wid      = rd_id;
                t_wtot     = rd_tot - dur_reg;
                state_next = pesta_pkg::ST_PUSH;
            end

            pesta_pkg::ST_PUSH:
            begin
                if (depth_reg == NC'(NEST_DEPTH))
                begin
                    sovf_next = 1'b1;
                end
                else
                begin
                    n_we       = 1'b1;
                    depth_next = depth_reg + NC'(1);
                end
                state_next = pesta_pkg::ST_IDLE;
            end

            // Selection pass: find first max total not yet emitted
            pesta_pkg::ST_SCAN:
            begin
                if (idx_reg != '0 && !done_reg[prev_idx] &&
                    (!hit_reg || rd_tot > best_reg))
                begin
                    hit_next  = 1'b1;
                    best_next = rd_tot;
                    slot_next = prev_idx;
                end
                if (idx_reg == used_reg)
                begin
                    if (used_reg == '0)
                    begin
                        state_next = pesta_pkg::ST_EMIT;
                    end
                    else
                    begin
                        rd_addr    = (idx_reg != '0 && !done_reg[prev_idx] &&
                                      (!hit_reg || rd_tot > best_reg)) ? prev_idx : slot_reg;
                        state_next = pesta_pkg::ST_EMIT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + TC'(1);
                end
            end

            pesta_pkg::ST_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next          = 1'b1;
                    out_next.table_overflow = tovf_reg;
                    out_next.stack_overflow = sovf_reg;
                    if (used_reg == '0)
                    begin
                        out_next.out_func_id = '0;
                        out_next.self_clocks = '0;
                        out_next.call_count  = '0;
                        out_next.entry_valid = 1'b0;
                        out_next.last        = 1'b1;
                        state_next           = pesta_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        out_next.out_func_id = 16'(rd_id);
                        out_next.self_clocks = rd_tot;
                        out_next.call_count  = rd_cnt;
                        out_next.entry_valid = 1'b1;
                        out_next.last        = (emitted_reg + TC'(1) == used_reg);
                        done_next[slot_reg]  = 1'b1;
                        emitted_next         = emitted_reg + TC'(1);
                        idx_next             = '0;
                        hit_next             = 1'b0;
                        state_next = (emitted_reg + TC'(1) == used_reg) ?
                                     pesta_pkg::ST_CLEAR : pesta_pkg::ST_SCAN;
                    end
                end
                else
                begin
                    rd_addr = slot_reg;
                end
            end

            pesta_pkg::ST_CLEAR:
            begin
                used_next  = '0;
                depth_next = '0;
                tovf_next  = 1'b0;
                sovf_next  = 1'b0;
                state_next = pesta_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = pesta_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= TC'(TABLE_ENTRIES))
        else $error("table fill count past capacity");
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= NC'(NEST_DEPTH))
        else $error("stack depth past capacity");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != pesta_pkg::ST_IDLE |-> !in_ready)
        else $error("input ready while busy");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pesta_pkg::ST_CLEAR |=> used_reg == '0 && !tovf_reg && !sovf_reg)
        else $error("dump did not clear state");
`endif

endmodule
